[hdl/bcp_pkg.sv]
// Shared types and constants of the bending curvature projection block.
package bcp_pkg;

	localparam int DATA_W     = 32;
	localparam int REST_W     = 31;
	localparam int NUM_VERT   = 4;
	localparam int NUM_LANES  = 3;
	localparam int RAD_W      = 2 * DATA_W;
	localparam int SQRT_STEPS = RAD_W / 2;
	localparam int DIV_STEPS  = DATA_W;
	localparam int LANE_STAGES = 3;
	// lane, merge, root, divider front, divider steps, output
	localparam int LAT = LANE_STAGES + 1 + SQRT_STEPS + 2 + DIV_STEPS + 1;
	localparam int E_DLY = 1 + SQRT_STEPS;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic [2:0] {
		CFG_WEIGHT_ZERO    = 3'd0,
		CFG_WEIGHT_ONE     = 3'd1,
		CFG_WEIGHT_TWO     = 3'd2,
		CFG_WEIGHT_THREE   = 3'd3,
		CFG_REST_CURVATURE = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [DATA_W-1:0] len;
		logic              zero;
	} len_info_t;

endpackage

[hdl/bcp_lane.sv]
// One coordinate lane: weighted sum of four positions, rounding, saturation, square.
module bcp_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           en,
	input  bcp_pkg::word_t weight [bcp_pkg::NUM_VERT],
	input  bcp_pkg::word_t pos    [bcp_pkg::NUM_VERT],
	output bcp_pkg::word_t e_s3,
	output logic [bcp_pkg::RAD_W-1:0] sq_s3
);
	import bcp_pkg::*;

	localparam int SUM_W = 2 * DATA_W + 2;
	localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (DATA_W - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (DATA_W - 1));

	logic signed [2*DATA_W-1:0] prod_s1 [NUM_VERT];
	logic signed [SUM_W-1:0]    acc;
	logic signed [SUM_W-1:0]    shifted;
	word_t                      e_next;
	word_t                      e_s2;
	logic [DATA_W-1:0]          mag;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_VERT; i++) begin
				prod_s1[i] <= (2*DATA_W)'(weight[i]) * (2*DATA_W)'(pos[i]);
			end
		end
	end

	always_comb begin
		acc = HALF;
		for (int i = 0; i < NUM_VERT; i++) begin
			acc = acc + SUM_W'(prod_s1[i]);
		end
		shifted = acc >>> FRAC_BITS;
		if (shifted > SAT_HI) begin
			e_next = word_t'(SAT_HI[DATA_W-1:0]);
		end else if (shifted < SAT_LO) begin
			e_next = word_t'(SAT_LO[DATA_W-1:0]);
		end else begin
			e_next = word_t'(shifted[DATA_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s2 <= e_next;
		end
	end

	// most negative value maps to 2^31 as unsigned
	assign mag = e_s2[DATA_W-1] ? DATA_W'(-e_s2) : DATA_W'(e_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= RAD_W'(mag) * RAD_W'(mag);
			e_s3  <= e_s2;
		end
	end

endmodule

[hdl/bcp_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
module bcp_isqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [bcp_pkg::RAD_W-1:0] rad,
	output logic [bcp_pkg::DATA_W-1:0] root
);
	import bcp_pkg::*;

	localparam int REM_W = DATA_W + 2;

	logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
	logic [DATA_W-1:0] root_q [SQRT_STEPS];
	logic [RAD_W-1:0]  val_q  [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [REM_W-1:0]  rem_i;
		logic [DATA_W-1:0] root_i;
		logic [RAD_W-1:0]  val_i;
		logic [REM_W+1:0]  r;
		logic [REM_W+1:0]  t;
		logic [REM_W+1:0]  d;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign val_i  = rad;
		end else begin : g_next
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign val_i  = val_q[k-1];
		end

		assign r = {rem_i, val_i[RAD_W-1 -: 2]};
		assign t = {2'b00, root_i, 2'b01};
		assign d = r - t;

		always_ff @(posedge clk) begin
			if (en) begin
				if (r >= t) begin
					rem_q[k]  <= d[REM_W-1:0];
					root_q[k] <= {root_i[DATA_W-2:0], 1'b1};
				end else begin
					rem_q[k]  <= r[REM_W-1:0];
					root_q[k] <= {root_i[DATA_W-2:0], 1'b0};
				end
				val_q[k] <= {val_i[RAD_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[SQRT_STEPS-1];

endmodule

[hdl/bcp_div.sv]
// Rescale of one lane: e * rest / len, rounded, by a pipelined restoring divider.
module bcp_div (
	input  logic                       clk,
	input  logic                       en,
	input  bcp_pkg::word_t             e_in,
	input  bcp_pkg::len_info_t         len_in,
	input  logic [bcp_pkg::REST_W-1:0] target,
	output bcp_pkg::word_t             result
);
	import bcp_pkg::*;

	localparam int NUM_W = DATA_W + REST_W;
	localparam logic [DATA_W-1:0] Q_LIM = DATA_W'(1) << (DATA_W - 1);
	localparam logic [DATA_W-1:0] Q_MAX = Q_LIM - DATA_W'(1);

	logic [DATA_W-1:0] mag;
	logic [NUM_W-1:0]  num_s1;
	logic [NUM_W-1:0]  num_s2;
	word_t             e_s1;
	word_t             e_s2;
	len_info_t         len_s1;
	len_info_t         len_s2;

	logic [DATA_W-1:0] rem_q  [DIV_STEPS];
	logic [DATA_W-1:0] quo_q  [DIV_STEPS];
	logic [DATA_W-1:0] low_q  [DIV_STEPS];
	word_t             e_q    [DIV_STEPS];
	len_info_t         len_q  [DIV_STEPS];

	logic [DATA_W-1:0] q_fin;
	logic [DATA_W-1:0] q_sat;
	word_t             scaled;
	word_t             result_q;

	assign mag = e_in[DATA_W-1] ? DATA_W'(-e_in) : DATA_W'(e_in);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= NUM_W'(mag) * NUM_W'(target);
			e_s1   <= e_in;
			len_s1 <= len_in;
			num_s2 <= num_s1 + NUM_W'(len_s1.len >> 1);
			e_s2   <= e_s1;
			len_s2 <= len_s1;
		end
	end

	// quotient stays below 2^32, so the upper dividend bits are below len
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [DATA_W-1:0] rem_i;
		logic [DATA_W-1:0] quo_i;
		logic [DATA_W-1:0] low_i;
		word_t             e_i;
		len_info_t         len_i;
		logic [DATA_W:0]   r;
		logic [DATA_W:0]   d;

		if (k == 0) begin : g_first
			assign rem_i = DATA_W'(num_s2[NUM_W-1:DATA_W]);
			assign quo_i = '0;
			assign low_i = num_s2[DATA_W-1:0];
			assign e_i   = e_s2;
			assign len_i = len_s2;
		end else begin : g_next
			assign rem_i = rem_q[k-1];
			assign quo_i = quo_q[k-1];
			assign low_i = low_q[k-1];
			assign e_i   = e_q[k-1];
			assign len_i = len_q[k-1];
		end

		assign r = {rem_i, low_i[DATA_W-1]};
		assign d = r - {1'b0, len_i.len};

		always_ff @(posedge clk) begin
			if (en) begin
				if (r >= {1'b0, len_i.len}) begin
					rem_q[k] <= d[DATA_W-1:0];
					quo_q[k] <= {quo_i[DATA_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= r[DATA_W-1:0];
					quo_q[k] <= {quo_i[DATA_W-2:0], 1'b0};
				end
				low_q[k] <= {low_i[DATA_W-2:0], 1'b0};
				e_q[k]   <= e_i;
				len_q[k] <= len_i;
			end
		end
	end

	assign q_fin = quo_q[DIV_STEPS-1];

	always_comb begin
		q_sat = (q_fin > Q_LIM) ? Q_LIM : q_fin;
		if (e_q[DIV_STEPS-1][DATA_W-1]) begin
			scaled = word_t'(-q_sat);
		end else if (q_sat[DATA_W-1]) begin
			scaled = word_t'(Q_MAX);
		end else begin
			scaled = word_t'(q_sat);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (target == '0) begin
				result_q <= '0;
			end else if (len_q[DIV_STEPS-1].zero) begin
				result_q <= e_q[DIV_STEPS-1];
			end else begin
				result_q <= scaled;
			end
		end
	end

	assign result = result_q;

endmodule

[hdl/bending_curvature_projection.sv]
// Pipeline of 3 lane, 1 merge, 32 root and 34 divider stages plus 1 output
// register; throughput one item per cycle when the output does not stall.
// Depth is set by the bit-per-stage square root and the three lane dividers.
// The whole pipeline holds while a result waits and m_tready is low.
// arst_n clears the valid chain and the configuration registers; data
// registers are not reset.
module bending_curvature_projection #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex3_z, 32 bits each
	input  logic [383:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// target_x, target_y, target_z, 32 bits each
	output logic [95:0]  m_tdata
);
	import bcp_pkg::*;

	word_t              weight_q [NUM_VERT];
	logic [REST_W-1:0]  rest_q;
	logic [LAT-1:0]     vld_q;
	logic               en;

	word_t              e_s3   [NUM_LANES];
	logic [RAD_W-1:0]   sq_s3  [NUM_LANES];
	logic [RAD_W-1:0]   sum_s4;
	logic [DATA_W-1:0]  len;
	len_info_t          len_info;
	word_t              e_dly_q [E_DLY][NUM_LANES];
	word_t              res    [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VERT; i++) begin
				weight_q[i] <= '0;
			end
			rest_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_WEIGHT_ZERO:    weight_q[0] <= word_t'(cfg_data);
				CFG_WEIGHT_ONE:     weight_q[1] <= word_t'(cfg_data);
				CFG_WEIGHT_TWO:     weight_q[2] <= word_t'(cfg_data);
				CFG_WEIGHT_THREE:   weight_q[3] <= word_t'(cfg_data);
				CFG_REST_CURVATURE: rest_q      <= cfg_data[REST_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
		word_t pos [NUM_VERT];

		for (genvar v = 0; v < NUM_VERT; v++) begin : g_pos
			assign pos[v] = word_t'(s_tdata[(v*NUM_LANES + c)*DATA_W +: DATA_W]);
		end

		bcp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.en     (en),
			.weight (weight_q),
			.pos    (pos),
			.e_s3   (e_s3[c]),
			.sq_s3  (sq_s3[c])
		);
	end

	// merge the lane squares into the squared length
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		end
	end

	bcp_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s4),
		.root (len)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_LANES; c++) begin
				e_dly_q[0][c] <= e_s3[c];
				for (int k = 1; k < E_DLY; k++) begin
					e_dly_q[k][c] <= e_dly_q[k-1][c];
				end
			end
		end
	end

	assign len_info.len  = len;
	assign len_info.zero = (len == '0);

	for (genvar c = 0; c < NUM_LANES; c++) begin : g_div
		bcp_div u_div (
			.clk    (clk),
			.en     (en),
			.e_in   (e_dly_q[E_DLY-1][c]),
			.len_in (len_info),
			.target (rest_q),
			.result (res[c])
		);
	end

	assign m_tdata = {res[2], res[1], res[0]};

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted transfer did not enter the pipeline");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(vld_q[LAT-2]))
		else $error("result appeared without an item in flight");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the bending curvature projection block.
`timescale 1ns / 1ps

class projection_board;
	logic signed [31:0] w [4];
	logic [30:0] rest;
	logic [95:0] pending [$];
	int errors;
	int shown;

	function new();
		foreach (w[i]) w[i] = 0;
		rest = 0;
		errors = 0;
		shown = 0;
	endfunction

	function void set_reg(bcp_pkg::cfg_index_t idx, logic [31:0] val);
		case (idx)
			bcp_pkg::CFG_WEIGHT_ZERO: w[0] = val;
			bcp_pkg::CFG_WEIGHT_ONE: w[1] = val;
			bcp_pkg::CFG_WEIGHT_TWO: w[2] = val;
			bcp_pkg::CFG_WEIGHT_THREE: w[3] = val;
			bcp_pkg::CFG_REST_CURVATURE: rest = val[30:0];
			default: ;
		endcase
	endfunction

	function logic signed [63:0] clamp(logic signed [127:0] v);
		if (v > 128'sd2147483647) return 64'sd2147483647;
		if (v < -128'sd2147483648) return -64'sd2147483648;
		return 64'(v);
	endfunction

	// weighted sum of one coordinate, round half up, saturated
	function logic signed [63:0] lap_sum(logic [383:0] d, int c);
		logic signed [127:0] acc;
		logic signed [31:0] p;
		acc = 0;
		for (int v = 0; v < 4; v++) begin
			p = d[(v*3+c)*32 +: 32];
			acc += 128'(w[v]) * 128'(p);
		end
		acc = (acc + (128'sd1 <<< 15)) >>> 16;
		return clamp(acc);
	endfunction

	function logic [63:0] root(logic [63:0] s);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function void note_input(logic [383:0] d);
		logic signed [63:0] e [3];
		logic [63:0] mag, len, sq;
		logic [127:0] q;
		logic [95:0] res;
		sq = 0;
		for (int c = 0; c < 3; c++) begin
			e[c] = lap_sum(d, c);
			mag = e[c] < 0 ? -e[c] : e[c];
			sq += mag * mag;
		end
		if (rest == 0) begin
			foreach (e[c]) e[c] = 0;
		end else begin
			len = root(sq);
			if (len > 0) begin
				for (int c = 0; c < 3; c++) begin
					mag = e[c] < 0 ? -e[c] : e[c];
					q = (128'(mag) * 128'(rest) + 128'(len / 2)) / 128'(len);
					if (q > 128'd2147483648) q = 128'd2147483648;
					e[c] = clamp(e[c] < 0 ? -$signed(q) : $signed(q));
				end
			end
		end
		for (int c = 0; c < 3; c++) res[c*32 +: 32] = e[c][31:0];
		pending.insert(pending.size(), res);
	endfunction

	function void check_result(logic [95:0] got);
		logic [95:0] exp;
		if (pending.size() == 0) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("unexpected result %h", got);
			end
			return;
		end
		exp = pending.pop_front();
		for (int c = 0; c < 3; c++)
			if (exp[c*32 +: 32] !== got[c*32 +: 32]) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("target lane %0d: expected %h, got %h", c,
						exp[c*32 +: 32], got[c*32 +: 32]);
				end
			end
	endfunction
endclass

module testbench;
	import bcp_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [383:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [95:0] m_tdata;

	int src_idle = 0;
	int snk_stall = 0;
	projection_board board = new();

	bending_curvature_projection DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_result(m_tdata);
		if (s_tvalid && s_tready) board.note_input(s_tdata);
	end

	always @(negedge clk)
		m_tready <= arst_n && ($urandom_range(99) >= snk_stall);

	// registers change only with the pipeline empty
	task automatic write_reg(cfg_index_t idx, logic [31:0] val);
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		@(negedge clk);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic send(logic [383:0] d);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LAT + 5) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(32'h3ffff) - 32'h1ffff;
			3: return 0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [383:0] rand_item(bit wide);
		logic [383:0] d;
		for (int i = 0; i < 12; i++)
			d[i*32 +: 32] = wide ? pick_word() : $urandom_range(32'h7ffff) - 32'h3ffff;
		return d;
	endfunction

	task automatic random_config();
		for (int i = 0; i < 4; i++)
			write_reg(cfg_index_t'(i), ($urandom_range(3) == 0) ? pick_word()
				: $urandom_range(32'h3ffff) - 32'h1ffff);
		write_reg(CFG_REST_CURVATURE, ($urandom_range(7) == 0) ? 0
			: ($urandom_range(3) == 0 ? {1'b0, 31'($urandom)} : $urandom_range(32'h7ffff)));
	endtask

	initial begin
		logic [383:0] d;
		repeat (4) @(negedge clk);
		arst_n <= 1;

		// rest curvature zero, then unit weights with extremes
		send({12{32'h7fffffff}});
		write_reg(CFG_WEIGHT_ZERO, 32'h00010000);
		write_reg(CFG_WEIGHT_ONE, 32'hffff0000);
		write_reg(CFG_WEIGHT_TWO, 32'h7fffffff);
		write_reg(CFG_WEIGHT_THREE, 32'h80000000);
		send({12{32'h80000000}});
		write_reg(CFG_REST_CURVATURE, 32'h7fffffff);
		send('0);  // zero length
		send({12{32'h7fffffff}});
		send({12{32'h80000000}});
		send({12{32'h00008000}});
		for (int i = 0; i < 8; i++) send(rand_item(1));
		write_reg(CFG_WEIGHT_TWO, 0);
		write_reg(CFG_WEIGHT_THREE, 0);
		write_reg(CFG_REST_CURVATURE, 32'h1);
		send('0);
		d = '0;
		d[31:0] = 32'h1;
		send(d);  // smallest nonzero x of vertex zero
		for (int i = 0; i < 6; i++) send(rand_item(0));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin src_idle = 0; snk_stall = 0; end
				1: begin src_idle = 69; snk_stall = 0; end
				2: begin src_idle = 0; snk_stall = 69; end
				default: begin src_idle = 38; snk_stall = 38; end
			endcase
			random_config();
			for (int i = 0; i < 235; i++) begin
				send(rand_item($urandom_range(2) == 0));
				if (i == 100) begin
					// hold off until the pipeline is empty
					s_tvalid <= 0;
					while (board.pending.size() != 0) @(negedge clk);
				end
			end
			drain();
		end

		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
